// File: rtl/core/scd_pkg.sv
// Shared types and constants for the moving average crossover detector.
package scd_pkg;

	localparam int WIN_BITS      = 9;
	localparam int PRICE_IN_BITS = 32;
	localparam int CFG_IDX_BITS  = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_WINDOW = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_WINDOW  = 2'd1;

	localparam logic [WIN_BITS-1:0] SHORT_WINDOW_RST = 9'd5;
	localparam logic [WIN_BITS-1:0] LONG_WINDOW_RST  = 9'd20;

	// Relation of the short average to the long average
	typedef enum logic [1:0] {
		REL_EQUAL = 2'd0,
		REL_ABOVE = 2'd1,
		REL_BELOW = 2'd2
	} rel_t;

	localparam logic signed [1:0] SIG_NONE = 2'sd0;
	localparam logic signed [1:0] SIG_BULL = 2'sd1;
	localparam logic signed [1:0] SIG_BEAR = -2'sd1;

	// Per-beat control flags that travel down the pipeline
	typedef struct packed {
		logic valid;      // beat present in this stage
		logic ok;         // configuration was usable for this beat
		logic has_short;  // short window already full before this beat
		logic has_long;   // long window already full before this beat
		logic first;      // long window was not full before this beat
		logic full;       // long window full after this beat
	} stage_ctl_t;

	typedef struct packed {
		logic signed [1:0] cross_signal;
		logic              window_full;
	} result_t;

endpackage

// File: rtl/core/sma_crossover_detector.sv
// Top level of the simple moving average crossover detector.
//
// Input stream (s_*): one closing price per beat in s_tdata, unsigned fixed
// point in units of 1e-4; the low PRICE_BITS bits are used, zero-extended if wider.
// Output stream (m_*): one result beat per input beat, in order:
// m_tdata[1:0] is the crossover (+1 bullish, -1 bearish, 0 none) and
// m_tdata[2] is set once the long window is full.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 short
// window, 1 long window) and clears sums, count, ring slot and relation.
// Write only while no beats are in flight.
// Pipeline: after its input beat is accepted, a result goes through the ring
// read, sum update and cross products stages, then the output register.
// Throughput: one beat per cycle while the receiver keeps up, set by the single
// ring write and the two registered ring reads each beat.
// Reset: windows return to 5 and 20, all state is cleared, both streams idle;
// no clearing pass is needed since ring entries are read only once written.
// Receiver stall: the output register plus one skid entry keep taking one
// more result; the whole pipeline and s_tready then hold until it drains.
module sma_crossover_detector import scd_pkg::*; #(
	parameter int MAX_WINDOW = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [PRICE_IN_BITS-1:0] s_tdata,   // [31:0] close_price
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [7:0]               m_tdata,   // [1:0] cross_signal, [2] window_full
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [WIN_BITS-1:0]      cfg_data
);

	localparam int SUM_BITS = PRICE_BITS + $clog2(MAX_WINDOW);

	logic [WIN_BITS-1:0]   short_window_q;
	logic [WIN_BITS-1:0]   long_window_q;
	logic                  cfg_clear;
	logic                  cfg_ok;
	logic                  advance;
	logic [PRICE_BITS-1:0] price;
	stage_ctl_t            ctl_s1;
	stage_ctl_t            ctl_s2;
	logic [PRICE_BITS-1:0] price_s1;
	logic [PRICE_BITS-1:0] old_short_s1;
	logic [PRICE_BITS-1:0] old_long_s1;
	logic                  short_nz_s2;
	logic [SUM_BITS-1:0]   short_sum;
	logic [SUM_BITS-1:0]   long_sum;
	logic                  push;
	result_t               result;
	result_t               out_data;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_window_q <= SHORT_WINDOW_RST;
			long_window_q  <= LONG_WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SHORT_WINDOW: short_window_q <= cfg_data;
				CFG_LONG_WINDOW:  long_window_q  <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign cfg_clear = cfg_we && (cfg_index == CFG_SHORT_WINDOW || cfg_index == CFG_LONG_WINDOW);

	assign cfg_ok = (short_window_q != '0) && (long_window_q != '0) &&
			(short_window_q < long_window_q) &&
			(32'(long_window_q) <= 32'(MAX_WINDOW));

	// Take the low PRICE_BITS of the price, zero-extending it when PRICE_BITS is wider
	generate
		if (PRICE_BITS <= PRICE_IN_BITS) begin : g_price_narrow
			assign price = s_tdata[PRICE_BITS-1:0];
		end else begin : g_price_wide
			assign price = {{(PRICE_BITS-PRICE_IN_BITS){1'b0}}, s_tdata};
		end
	endgenerate

	assign s_tready = advance;

	scd_history #(
		.MAX_WINDOW (MAX_WINDOW),
		.PRICE_BITS (PRICE_BITS)
	) u_history (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_clear),
		.advance      (advance),
		.in_valid     (s_tvalid),
		.cfg_ok       (cfg_ok),
		.short_window (short_window_q),
		.long_window  (long_window_q),
		.price        (price),
		.ctl_s1       (ctl_s1),
		.price_s1     (price_s1),
		.old_short_s1 (old_short_s1),
		.old_long_s1  (old_long_s1)
	);

	scd_sums #(
		.MAX_WINDOW (MAX_WINDOW),
		.PRICE_BITS (PRICE_BITS)
	) u_sums (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_clear),
		.advance      (advance),
		.ctl_s1       (ctl_s1),
		.price_s1     (price_s1),
		.old_short_s1 (old_short_s1),
		.old_long_s1  (old_long_s1),
		.ctl_s2       (ctl_s2),
		.short_nz_s2  (short_nz_s2),
		.short_sum_q  (short_sum),
		.long_sum_q   (long_sum)
	);

	scd_compare #(
		.SUM_BITS (SUM_BITS)
	) u_compare (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_clear),
		.advance      (advance),
		.ctl_s2       (ctl_s2),
		.short_nz_s2  (short_nz_s2),
		.short_sum    (short_sum),
		.long_sum     (long_sum),
		.short_window (short_window_q),
		.long_window  (long_window_q),
		.push         (push),
		.result       (result)
	);

	scd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.din      (result),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.dout     (out_data),
		.advance  (advance)
	);

	assign m_tdata = {5'b0, out_data.window_full, out_data.cross_signal};

endmodule

// File: rtl/core/scd_history.sv
// Price ring: stores usable-config prices and fetches those leaving both windows.
module scd_history import scd_pkg::*; #(
	parameter int MAX_WINDOW = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  advance,
	input  logic                  in_valid,
	input  logic                  cfg_ok,
	input  logic [WIN_BITS-1:0]   short_window,
	input  logic [WIN_BITS-1:0]   long_window,
	input  logic [PRICE_BITS-1:0] price,
	output stage_ctl_t            ctl_s1,
	output logic [PRICE_BITS-1:0] price_s1,
	output logic [PRICE_BITS-1:0] old_short_s1,
	output logic [PRICE_BITS-1:0] old_long_s1
);

	localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int DW = ((AW > WIN_BITS) ? AW : WIN_BITS) + 1;

	logic [PRICE_BITS-1:0] hist_mem_q [MAX_WINDOW];
	logic [AW-1:0]         slot_q;
	logic [WIN_BITS-1:0]   seen_q;
	logic [WIN_BITS-1:0]   seen_next;
	logic                  accept;
	logic                  update;
	logic [DW-1:0]         slot_ext;
	logic [DW-1:0]         short_diff;
	logic [DW-1:0]         long_diff;
	logic [DW-1:0]         short_wrap;
	logic [DW-1:0]         long_wrap;
	logic [AW-1:0]         short_addr;
	logic [AW-1:0]         long_addr;
	stage_ctl_t            ctl_in;

	assign accept = advance & in_valid;
	assign update = accept & cfg_ok;

	// Step back from the write slot by each window length, wrapping the ring
	always_comb begin
		slot_ext   = DW'(slot_q);
		short_diff = slot_ext - DW'(short_window);
		long_diff  = slot_ext - DW'(long_window);
		short_wrap = short_diff + DW'(MAX_WINDOW);
		long_wrap  = long_diff + DW'(MAX_WINDOW);
		short_addr = (slot_ext >= DW'(short_window)) ? short_diff[AW-1:0] : short_wrap[AW-1:0];
		long_addr  = (slot_ext >= DW'(long_window)) ? long_diff[AW-1:0] : long_wrap[AW-1:0];
	end

	// Sample count saturates at the long window length
	assign seen_next = (seen_q < long_window) ? seen_q + 1'b1 : seen_q;

	always_comb begin
		ctl_in.valid     = 1'b1;
		ctl_in.ok        = cfg_ok;
		ctl_in.has_short = seen_q >= short_window;
		ctl_in.has_long  = seen_q >= long_window;
		ctl_in.first     = seen_q < long_window;
		ctl_in.full      = cfg_ok & (seen_next >= long_window);
	end

	// Advance slot and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			seen_q <= '0;
		end else if (clear) begin
			slot_q <= '0;
			seen_q <= '0;
		end else if (update) begin
			slot_q <= (slot_q == AW'(MAX_WINDOW - 1)) ? '0 : slot_q + 1'b1;
			seen_q <= seen_next;
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1 <= accept ? ctl_in : '0;
		end
	end

	// Ring memory: one write, two registered reads (read returns the old entry)
	always_ff @(posedge clk) begin
		if (update) begin
			hist_mem_q[slot_q] <= price;
		end
		if (accept) begin
			old_short_s1 <= hist_mem_q[short_addr];
			old_long_s1  <= hist_mem_q[long_addr];
			price_s1     <= price;
		end
	end

endmodule

// File: rtl/core/scd_sums.sv
// Running window sums: add the new price and drop the one leaving each window.
module scd_sums import scd_pkg::*; #(
	parameter int MAX_WINDOW = 256,
	parameter int PRICE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  clear,
	input  logic                  advance,
	input  stage_ctl_t            ctl_s1,
	input  logic [PRICE_BITS-1:0] price_s1,
	input  logic [PRICE_BITS-1:0] old_short_s1,
	input  logic [PRICE_BITS-1:0] old_long_s1,
	output stage_ctl_t            ctl_s2,
	output logic                  short_nz_s2,
	output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] short_sum_q,
	output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] long_sum_q
);

	localparam int SUM_BITS = PRICE_BITS + $clog2(MAX_WINDOW);

	logic [SUM_BITS-1:0] price_ext;
	logic [SUM_BITS-1:0] short_drop;
	logic [SUM_BITS-1:0] long_drop;
	logic                update;

	assign price_ext  = SUM_BITS'(price_s1);
	assign short_drop = ctl_s1.has_short ? SUM_BITS'(old_short_s1) : '0;
	assign long_drop  = ctl_s1.has_long ? SUM_BITS'(old_long_s1) : '0;
	assign update     = advance & ctl_s1.valid & ctl_s1.ok;

	// Update both sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_sum_q <= '0;
			long_sum_q  <= '0;
		end else if (clear) begin
			short_sum_q <= '0;
			long_sum_q  <= '0;
		end else if (update) begin
			short_sum_q <= short_sum_q + price_ext - short_drop;
			long_sum_q  <= long_sum_q + price_ext - long_drop;
		end
	end

	// Stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (advance) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Remember whether the short sum was nonzero before this beat
	always_ff @(posedge clk) begin
		if (advance) begin
			short_nz_s2 <= (short_sum_q != '0);
		end
	end

endmodule

// File: rtl/core/scd_compare.sv
// Cross-multiplied average comparison and crossover decision.
module scd_compare import scd_pkg::*; #(
	parameter int SUM_BITS = 40
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clear,
	input  logic                advance,
	input  stage_ctl_t          ctl_s2,
	input  logic                short_nz_s2,
	input  logic [SUM_BITS-1:0] short_sum,
	input  logic [SUM_BITS-1:0] long_sum,
	input  logic [WIN_BITS-1:0] short_window,
	input  logic [WIN_BITS-1:0] long_window,
	output logic                push,
	output result_t             result
);

	localparam int PW = SUM_BITS + WIN_BITS;

	stage_ctl_t    ctl_s3;
	logic          short_nz_s3;
	logic [PW-1:0] prod_a_s3;
	logic [PW-1:0] prod_b_s3;
	rel_t          prev_rel_q;
	rel_t          prev_rel;
	rel_t          cur_rel;

	// Stage 3: cross products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else if (advance) begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_a_s3   <= PW'(short_sum) * PW'(long_window);
			prod_b_s3   <= PW'(long_sum) * PW'(short_window);
			short_nz_s3 <= short_nz_s2;
		end
	end

	// Compare and decide; on the first full beat the old long average counts as zero
	always_comb begin
		if (prod_a_s3 > prod_b_s3) begin
			cur_rel = REL_ABOVE;
		end else if (prod_a_s3 < prod_b_s3) begin
			cur_rel = REL_BELOW;
		end else begin
			cur_rel = REL_EQUAL;
		end
		if (ctl_s3.first) begin
			prev_rel = short_nz_s3 ? REL_ABOVE : REL_EQUAL;
		end else begin
			prev_rel = prev_rel_q;
		end
		result.window_full  = ctl_s3.full;
		result.cross_signal = SIG_NONE;
		if (ctl_s3.full) begin
			if (prev_rel != REL_ABOVE && cur_rel == REL_ABOVE) begin
				result.cross_signal = SIG_BULL;
			end else if (prev_rel != REL_BELOW && cur_rel == REL_BELOW) begin
				result.cross_signal = SIG_BEAR;
			end
		end
	end

	assign push = advance & ctl_s3.valid;

	// Hold the relation for the next beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_rel_q <= REL_EQUAL;
		end else if (clear) begin
			prev_rel_q <= REL_EQUAL;
		end else if (push && ctl_s3.full) begin
			prev_rel_q <= cur_rel;
		end
	end

endmodule

// File: rtl/core/scd_out_buf.sv
// Output register with one skid entry between the pipeline and the receiver.
module scd_out_buf import scd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	input  logic    m_tready,
	output logic    m_tvalid,
	output result_t dout,
	output logic    advance
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    out_free;
	logic    load_out;
	logic    load_skid;
	logic    drain_skid;

	assign out_free   = !out_valid_q || m_tready;
	assign drain_skid = skid_valid_q && m_tready;
	assign load_out   = push && out_free;
	assign load_skid  = push && !out_free;
	assign advance    = !skid_valid_q;
	assign m_tvalid   = out_valid_q;
	assign dout       = out_q;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (load_skid) begin
			skid_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (drain_skid) begin
			out_q <= skid_q;
		end else if (load_out) begin
			out_q <= din;
		end
		if (load_skid) begin
			skid_q <= din;
		end
	end

endmodule
